FILE: rtl/core/kpr_pkg.sv
// kpr_pkg: shared types and constants for the keyframe path recorder/player
// used by kpr_front, kpr_back and the top level; depends on nothing else
`default_nettype none

package kpr_pkg;

  localparam int NUM_SLOTS  = 4;
  localparam int MAX_KEYS   = 64;
  localparam int SLOT_W     = 2;
  localparam int KEY_W      = 6;
  localparam int CNT_W      = 7;
  localparam int ADDR_W     = SLOT_W + KEY_W;
  localparam int MEM_DEPTH  = NUM_SLOTS * MAX_KEYS;
  localparam int POSE_W     = 32;
  localparam int DT_W       = 31;
  localparam int RECIP_W    = 32;
  localparam int FRAC_W     = 17;
  localparam int STEP_W     = DT_W + RECIP_W - 16;
  localparam int DIFF_W     = 34;
  localparam int PROD_W     = DIFF_W + FRAC_W + 1;
  localparam int CD_W       = 33;
  localparam int KEY_DATA_W = 5 * POSE_W;

  localparam logic signed [DIFF_W-1:0] PI_Q     = 34'sd205887;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 34'sd411775;
  localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
  localparam logic [FRAC_W-1:0] FRAC_LIMIT = 17'd64880;
  localparam logic [CNT_W-1:0]  KEYS_MAX   = 7'd64;

  localparam logic [DT_W-1:0]    KEY_INTERVAL_RST = 31'd65536;
  localparam logic [RECIP_W-1:0] RECIP_RST        = 32'd65536;

  localparam logic CFG_KEY_INTERVAL = 1'b0;
  localparam logic CFG_RECIP        = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_FINISH = 3'd2,
    OP_CANCEL = 3'd3,
    OP_FOLLOW = 3'd4,
    OP_STOP   = 3'd5,
    OP_BAD    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_REC    = 2'd1,
    MODE_FOLLOW = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic [POSE_W-1:0] x;
    logic [POSE_W-1:0] y;
    logic [POSE_W-1:0] z;
    logic [POSE_W-1:0] yaw;
    logic [POSE_W-1:0] pitch;
  } key_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [DT_W-1:0]   dt;
    key_t              pose;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/kpr_ram.sv
// kpr_ram: generic single write port / single read port ram, registered read
// standalone, no package dependency
`default_nettype none

module kpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/kpr_front.sv
// kpr_front: accepts input transactions, decodes the request and queues commands
// depends on kpr_pkg
`default_nettype none

module kpr_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    req_type,
  input  wire logic [kpr_pkg::SLOT_W-1:0]    path_slot,
  input  wire logic [kpr_pkg::DT_W-1:0]      dt,
  input  wire logic signed [kpr_pkg::POSE_W-1:0] cam_x,
  input  wire logic signed [kpr_pkg::POSE_W-1:0] cam_y,
  input  wire logic signed [kpr_pkg::POSE_W-1:0] cam_z,
  input  wire logic signed [kpr_pkg::POSE_W-1:0] cam_yaw,
  input  wire logic signed [kpr_pkg::POSE_W-1:0] cam_pitch,
  output logic                               q_valid,
  output kpr_pkg::cmd_t                      q_cmd,
  input  wire logic                          q_pop
);

  kpr_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  kpr_pkg::op_t  op_dec;
  logic          push;
  logic          pop;

  always_comb begin
    unique case (req_type)
      3'd0:    op_dec = kpr_pkg::OP_TICK;
      3'd1:    op_dec = kpr_pkg::OP_START;
      3'd2:    op_dec = kpr_pkg::OP_FINISH;
      3'd3:    op_dec = kpr_pkg::OP_CANCEL;
      3'd4:    op_dec = kpr_pkg::OP_FOLLOW;
      3'd5:    op_dec = kpr_pkg::OP_STOP;
      default: op_dec = kpr_pkg::OP_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: op_dec, slot: path_slot, dt: dt,
                            pose: '{x: cam_x, y: cam_y, z: cam_z,
                                    yaw: cam_yaw, pitch: cam_pitch}};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kpr_back.sv
// kpr_back: executes queued commands, owns the key memory and the output register
// depends on kpr_pkg and kpr_ram
`default_nettype none

module kpr_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire kpr_pkg::cmd_t                 q_cmd,
  output logic                               q_pop,
  input  wire logic [kpr_pkg::DT_W-1:0]      key_interval,
  input  wire logic [kpr_pkg::RECIP_W-1:0]   interval_reciprocal,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               pose_valid,
  output logic signed [kpr_pkg::POSE_W-1:0]  pose_x,
  output logic signed [kpr_pkg::POSE_W-1:0]  pose_y,
  output logic signed [kpr_pkg::POSE_W-1:0]  pose_z,
  output logic signed [kpr_pkg::POSE_W-1:0]  pose_yaw,
  output logic signed [kpr_pkg::POSE_W-1:0]  pose_pitch,
  output logic [1:0]                         mode_now,
  output logic [kpr_pkg::CNT_W-1:0]          key_count,
  output logic [1:0]                         status
);

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_RDB, S_ADJ, S_MUL, S_SUM
  } state_t;

  localparam int DW = kpr_pkg::DIFF_W;
  localparam int PW = kpr_pkg::PROD_W;

  state_t state, state_next;

  kpr_pkg::mode_t            mode, mode_next;
  logic [kpr_pkg::SLOT_W-1:0] aslot, aslot_next;
  logic [kpr_pkg::KEY_W-1:0]  seg, seg_next;
  logic [kpr_pkg::FRAC_W-1:0] frac, frac_next;
  logic signed [kpr_pkg::CD_W-1:0] cd, cd_next;
  logic [kpr_pkg::CNT_W-1:0]  counts [kpr_pkg::NUM_SLOTS];
  logic [kpr_pkg::CNT_W-1:0]  counts_next [kpr_pkg::NUM_SLOTS];
  logic [kpr_pkg::STEP_W-1:0] step, step_next;

  kpr_pkg::key_t     key_a, key_a_next;
  logic signed [DW-1:0] diff [5];
  logic signed [DW-1:0] diff_next [5];
  logic signed [DW-1:0] yaw_base, yaw_base_next;
  logic signed [PW-1:0] prod [5];
  logic signed [PW-1:0] prod_next [5];

  // ram port
  logic                         we;
  logic [kpr_pkg::ADDR_W-1:0]   waddr;
  logic [kpr_pkg::ADDR_W-1:0]   raddr;
  logic [kpr_pkg::KEY_DATA_W-1:0] rdata;
  kpr_pkg::key_t                key_b;

  // output register next values
  logic                          out_valid_next;
  logic                          pose_valid_next;
  logic signed [kpr_pkg::POSE_W-1:0] pose_next [5];
  logic [1:0]                    mode_now_next;
  logic [kpr_pkg::CNT_W-1:0]     key_count_next;
  logic [1:0]                    status_next;

  // scratch
  logic                          free;
  logic                          done;
  kpr_pkg::status_t              st;
  logic                          save_en;
  logic [kpr_pkg::SLOT_W-1:0]    save_slot;
  logic [kpr_pkg::CNT_W-1:0]     save_n;
  logic signed [kpr_pkg::CD_W-1:0] cd_sub;
  logic [kpr_pkg::DT_W+kpr_pkg::RECIP_W-1:0] step_full;
  logic signed [DW-1:0]          d_yaw;
  logic [kpr_pkg::FRAC_W-1:0]    frac_rem;
  logic [kpr_pkg::FRAC_W-1:0]    frac_new;
  logic [kpr_pkg::CNT_W-1:0]     seg_p1;
  logic [kpr_pkg::CNT_W-1:0]     seg_p2;
  logic signed [DW+2:0]          sum [5];
  logic signed [DW-1:0]          base [5];

  kpr_ram #(
    .WIDTH (kpr_pkg::KEY_DATA_W),
    .DEPTH (kpr_pkg::MEM_DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_cmd.pose),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign key_b     = kpr_pkg::key_t'(rdata);
  assign free      = !out_valid || !out_stall;
  assign step_full = q_cmd.dt * interval_reciprocal;
  assign seg_p1    = {1'b0, seg} + 7'd1;
  assign seg_p2    = {1'b0, seg} + 7'd2;

  assign base[0] = {{2{key_a.x[31]}}, key_a.x};
  assign base[1] = {{2{key_a.y[31]}}, key_a.y};
  assign base[2] = {{2{key_a.z[31]}}, key_a.z};
  assign base[3] = yaw_base;
  assign base[4] = {{2{key_a.pitch[31]}}, key_a.pitch};

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      sum[k] = {{3{base[k][DW-1]}}, base[k]}
             + {{(DW+3-(PW-16)){prod[k][PW-1]}}, prod[k][PW-1:16]};
    end
  end

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    aslot_next  = aslot;
    seg_next    = seg;
    frac_next   = frac;
    cd_next     = cd;
    step_next   = step;
    key_a_next  = key_a;
    yaw_base_next = yaw_base;
    for (int k = 0; k < kpr_pkg::NUM_SLOTS; k++) begin
      counts_next[k] = counts[k];
    end
    for (int k = 0; k < 5; k++) begin
      diff_next[k] = diff[k];
      prod_next[k] = prod[k];
      pose_next[k] = '0;
    end
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = {aslot, seg};
    raddr     = {aslot, seg};
    done      = 1'b0;
    st        = kpr_pkg::ST_OK;
    save_en   = 1'b0;
    save_slot = aslot;
    save_n    = counts[aslot];
    cd_sub    = cd - $signed({2'b00, q_cmd.dt});
    d_yaw     = '0;
    frac_rem  = kpr_pkg::FRAC_ONE - frac;
    frac_new  = frac;
    pose_valid_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid && free) begin
          q_pop = 1'b1;
          done  = 1'b1;
          unique case (q_cmd.op)
            kpr_pkg::OP_TICK: begin
              if (mode == kpr_pkg::MODE_REC) begin
                if (cd_sub < 0) begin
                  save_en = 1'b1;
                end else begin
                  cd_next = cd_sub;
                end
              end else if (mode == kpr_pkg::MODE_FOLLOW) begin
                if (seg_p1 < counts[aslot]) begin
                  done       = 1'b0;
                  step_next  = step_full[kpr_pkg::DT_W+kpr_pkg::RECIP_W-1:16];
                  state_next = S_RDA;
                end else begin
                  mode_next = kpr_pkg::MODE_IDLE;
                end
              end
            end
            kpr_pkg::OP_START: begin
              if (mode != kpr_pkg::MODE_IDLE) begin
                st = kpr_pkg::ST_IGNORED;
              end else begin
                aslot_next = q_cmd.slot;
                mode_next  = kpr_pkg::MODE_REC;
                save_en    = 1'b1;
                save_slot  = q_cmd.slot;
                save_n     = '0;
              end
            end
            kpr_pkg::OP_FINISH: begin
              if (mode != kpr_pkg::MODE_REC) begin
                st = kpr_pkg::ST_IGNORED;
              end else begin
                save_en   = 1'b1;
                mode_next = kpr_pkg::MODE_IDLE;
              end
            end
            kpr_pkg::OP_CANCEL: begin
              if (mode != kpr_pkg::MODE_REC) begin
                st = kpr_pkg::ST_IGNORED;
              end else begin
                counts_next[aslot] = '0;
                mode_next          = kpr_pkg::MODE_IDLE;
              end
            end
            kpr_pkg::OP_FOLLOW: begin
              if (mode == kpr_pkg::MODE_REC || counts[q_cmd.slot] < 7'd2) begin
                st = kpr_pkg::ST_IGNORED;
              end else begin
                mode_next  = kpr_pkg::MODE_FOLLOW;
                aslot_next = q_cmd.slot;
                seg_next   = '0;
                frac_next  = '0;
              end
            end
            kpr_pkg::OP_STOP: begin
              if (mode != kpr_pkg::MODE_FOLLOW) begin
                st = kpr_pkg::ST_IGNORED;
              end else begin
                mode_next = kpr_pkg::MODE_IDLE;
              end
            end
            default: begin
              st = kpr_pkg::ST_IGNORED;
            end
          endcase

          if (save_en) begin
            cd_next = $signed({2'b00, key_interval});
            if (save_n < kpr_pkg::KEYS_MAX) begin
              we                     = 1'b1;
              waddr                  = {save_slot, save_n[kpr_pkg::KEY_W-1:0]};
              counts_next[save_slot] = save_n + 7'd1;
            end else begin
              st = kpr_pkg::ST_FULL;
            end
          end
        end
      end
      S_RDA: begin
        state_next = S_RDB;
      end
      S_RDB: begin
        // data of key i arrives, fetch key i+1
        raddr      = {aslot, seg_p1[kpr_pkg::KEY_W-1:0]};
        key_a_next = key_b;
        state_next = S_ADJ;
      end
      S_ADJ: begin
        diff_next[0] = $signed({{2{key_b.x[31]}}, key_b.x}) - base[0];
        diff_next[1] = $signed({{2{key_b.y[31]}}, key_b.y}) - base[1];
        diff_next[2] = $signed({{2{key_b.z[31]}}, key_b.z}) - base[2];
        diff_next[4] = $signed({{2{key_b.pitch[31]}}, key_b.pitch}) - base[4];
        d_yaw = $signed({{2{key_b.yaw[31]}}, key_b.yaw})
              - $signed({{2{key_a.yaw[31]}}, key_a.yaw});
        yaw_base_next = $signed({{2{key_a.yaw[31]}}, key_a.yaw});
        diff_next[3]  = d_yaw;
        // short way around for yaw
        if (d_yaw > kpr_pkg::PI_Q) begin
          yaw_base_next = $signed({{2{key_a.yaw[31]}}, key_a.yaw}) + kpr_pkg::TWO_PI_Q;
          diff_next[3]  = d_yaw - kpr_pkg::TWO_PI_Q;
        end else if (d_yaw < -kpr_pkg::PI_Q) begin
          diff_next[3]  = d_yaw + kpr_pkg::TWO_PI_Q;
        end
        state_next = S_MUL;
      end
      S_MUL: begin
        for (int k = 0; k < 5; k++) begin
          prod_next[k] = diff[k] * $signed({1'b0, frac});
        end
        state_next = S_SUM;
      end
      S_SUM: begin
        done            = 1'b1;
        pose_valid_next = 1'b1;
        pose_next[0] = sum[0][kpr_pkg::POSE_W-1:0];
        pose_next[1] = sum[1][kpr_pkg::POSE_W-1:0];
        pose_next[2] = sum[2][kpr_pkg::POSE_W-1:0];
        pose_next[4] = sum[4][kpr_pkg::POSE_W-1:0];
        if (sum[3] > $signed({{(DW+3-32){1'b0}}, 32'h7FFF_FFFF})) begin
          pose_next[3] = 32'sh7FFF_FFFF;
        end else if (sum[3] < $signed({{(DW+3-32){1'b1}}, 32'h8000_0000})) begin
          pose_next[3] = 32'sh8000_0000;
        end else begin
          pose_next[3] = sum[3][kpr_pkg::POSE_W-1:0];
        end
        if (step >= {{(kpr_pkg::STEP_W-kpr_pkg::FRAC_W){1'b0}}, frac_rem}) begin
          frac_new = kpr_pkg::FRAC_ONE;
        end else begin
          frac_new = frac + step[kpr_pkg::FRAC_W-1:0];
        end
        frac_next = frac_new;
        if (frac_new > kpr_pkg::FRAC_LIMIT) begin
          frac_next = '0;
          seg_next  = seg_p1[kpr_pkg::KEY_W-1:0];
          if (seg_p2 >= counts[aslot]) begin
            mode_next = kpr_pkg::MODE_IDLE;
          end
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_valid && out_stall;
    if (done) begin
      out_valid_next = 1'b1;
    end
    mode_now_next  = mode_next;
    key_count_next = counts_next[aslot_next];
    status_next    = st;
  end

  always_ff @(posedge clk) begin
    step     <= step_next;
    key_a    <= key_a_next;
    yaw_base <= yaw_base_next;
    for (int k = 0; k < 5; k++) begin
      diff[k] <= diff_next[k];
      prod[k] <= prod_next[k];
    end
    if (done) begin
      pose_valid <= pose_valid_next;
      pose_x     <= pose_next[0];
      pose_y     <= pose_next[1];
      pose_z     <= pose_next[2];
      pose_yaw   <= pose_next[3];
      pose_pitch <= pose_next[4];
      mode_now   <= mode_now_next;
      key_count  <= key_count_next;
      status     <= status_next;
    end
    if (rst) begin
      state     <= S_IDLE;
      mode      <= kpr_pkg::MODE_IDLE;
      aslot     <= '0;
      seg       <= '0;
      frac      <= '0;
      cd        <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < kpr_pkg::NUM_SLOTS; k++) begin
        counts[k] <= '0;
      end
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      aslot     <= aslot_next;
      seg       <= seg_next;
      frac      <= frac_next;
      cd        <= cd_next;
      out_valid <= out_valid_next;
      for (int k = 0; k < kpr_pkg::NUM_SLOTS; k++) begin
        counts[k] <= counts_next[k];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/keyframe_path_record_playback.sv
// keyframe_path_record_playback: top level, config registers and the apb port
// depends on kpr_pkg, kpr_front, kpr_back (and kpr_ram through kpr_back)
//
// usage: one request transaction in (in_valid/in_stall), one result transaction
// out (out_valid/out_stall) per request, in order. requests are tick, start,
// finish, cancel, follow and stop; ticks while recording store keys on countdown
// expiry, ticks while following return a blended pose from two adjacent keys.
// a two-entry command queue parts the input side from the executing side, so
// requests keep flowing in while a result waits to be taken.
// a control request or a recording tick is handled in S_IDLE as it leaves the
// queue and its result is registered, showing in the next cycle; a following
// tick steps through S_IDLE, S_RDA, S_RDB, S_ADJ, S_MUL and S_SUM (two key reads
// on the single ram read port, yaw adjust, multiply, sum). other requests go one
// per cycle while the output register is free; none is taken during a following tick.
// reset (rst, synchronous) empties the queue and the output register, sets mode
// idle and all slot key counts to zero; key memory contents are kept as is.
// config (key_interval at 0x0, interval_reciprocal at 0x4) is written over apb;
// the user must write it only while no transaction is in flight, the block does
// not enforce this. a stalled result holds its value, and once the queue is full in_stall rises.
`default_nettype none

module keyframe_path_record_playback (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [1:0]  path_slot,
  input  wire logic [30:0] dt,
  input  wire logic signed [31:0] cam_x,
  input  wire logic signed [31:0] cam_y,
  input  wire logic signed [31:0] cam_z,
  input  wire logic signed [31:0] cam_yaw,
  input  wire logic signed [31:0] cam_pitch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             pose_valid,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] pose_z,
  output logic signed [31:0] pose_yaw,
  output logic signed [31:0] pose_pitch,
  output logic [1:0]       mode_now,
  output logic [6:0]       key_count,
  output logic [1:0]       status
);

  logic [kpr_pkg::DT_W-1:0]    key_interval;
  logic [kpr_pkg::RECIP_W-1:0] interval_reciprocal;
  logic                        cfg_wr;
  logic                        q_valid;
  logic                        q_pop;
  kpr_pkg::cmd_t               q_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      kpr_pkg::CFG_KEY_INTERVAL: prdata = {1'b0, key_interval};
      kpr_pkg::CFG_RECIP:        prdata = interval_reciprocal;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_interval        <= kpr_pkg::KEY_INTERVAL_RST;
      interval_reciprocal <= kpr_pkg::RECIP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == kpr_pkg::CFG_KEY_INTERVAL) begin
        key_interval <= pwdata[kpr_pkg::DT_W-1:0];
      end else begin
        interval_reciprocal <= pwdata;
      end
    end
  end

  kpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .path_slot (path_slot),
    .dt        (dt),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z),
    .cam_yaw   (cam_yaw),
    .cam_pitch (cam_pitch),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  kpr_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .q_pop               (q_pop),
    .key_interval        (key_interval),
    .interval_reciprocal (interval_reciprocal),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .pose_valid          (pose_valid),
    .pose_x              (pose_x),
    .pose_y              (pose_y),
    .pose_z              (pose_z),
    .pose_yaw            (pose_yaw),
    .pose_pitch          (pose_pitch),
    .mode_now            (mode_now),
    .key_count           (key_count),
    .status              (status)
  );

endmodule

`default_nettype wire

FILE: sim/keyframe_path_record_playback_test.sv
// keyframe_path_record_playback_test: self-checking bench for the path recorder/player
// drives requests and apb writes, predicts every result in-bench; needs kpr_pkg and the rtl
`timescale 1ns / 1ps

module keyframe_path_record_playback_test;

  typedef struct packed {
    logic [2:0]  req;
    logic [1:0]  slot;
    logic [30:0] dt;
    logic [31:0] x, y, z, yaw, pitch;
  } req_item_t;

  typedef struct packed {
    logic        pv;
    logic [31:0] x, y, z, yaw, pitch;
    logic [1:0]  mode;
    logic [6:0]  cnt;
    logic [1:0]  st;
  } pose_result_t;

  localparam logic [2:0] ADDR_KEY_INTERVAL = 3'd0;
  localparam logic [2:0] ADDR_RECIP        = 3'd4;
  localparam logic [2:0] REQ_RSVD          = 3'd7;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] req_type = 0;
  logic [1:0] path_slot = 0;
  logic [30:0] dt = 0;
  logic signed [31:0] cam_x = 0, cam_y = 0, cam_z = 0, cam_yaw = 0, cam_pitch = 0;
  logic out_valid;
  logic out_stall = 0;
  logic pose_valid;
  logic signed [31:0] pose_x, pose_y, pose_z, pose_yaw, pose_pitch;
  logic [1:0] mode_now;
  logic [6:0] key_count;
  logic [1:0] status;

  keyframe_path_record_playback i_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] kx[kpr_pkg::MEM_DEPTH], ky[kpr_pkg::MEM_DEPTH], kz[kpr_pkg::MEM_DEPTH];
  logic [31:0] kyaw[kpr_pkg::MEM_DEPTH], kpitch[kpr_pkg::MEM_DEPTH];
  int unsigned slot_keys[kpr_pkg::NUM_SLOTS];
  kpr_pkg::mode_t p_mode;
  int unsigned p_slot, p_seg, p_frac;
  longint p_countdown;
  longint unsigned p_interval, p_recip;

  req_item_t pending_reqs[$];
  pose_result_t expected_poses[$];
  int errors = 0;
  longint cycles = 0;
  int items_added = 0;
  bit in_taken = 0;
  bit out_taken = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint lerp_q16(longint a, longint b, int unsigned f);
    longint s;
    s = a * (65536 - longint'(f)) + b * longint'(f);
    return s >>> 16;  // arithmetic shift is floor division
  endfunction

  function automatic logic [1:0] store_pose(req_item_t r);
    int unsigned n, a;
    logic [1:0] st;
    st = kpr_pkg::ST_OK;
    n = slot_keys[p_slot];
    if (n < kpr_pkg::MAX_KEYS) begin
      a = p_slot * kpr_pkg::MAX_KEYS + n;
      kx[a] = r.x; ky[a] = r.y; kz[a] = r.z; kyaw[a] = r.yaw; kpitch[a] = r.pitch;
      slot_keys[p_slot] = n + 1;
    end else begin
      st = kpr_pkg::ST_FULL;
    end
    p_countdown = longint'(p_interval);
    return st;
  endfunction

  function automatic pose_result_t predict_pose(req_item_t r);
    pose_result_t o;
    int unsigned n, a, f;
    longint cy, ny, yv;
    longint unsigned inc;
    o = '0;
    o.st = kpr_pkg::ST_OK;
    case (r.req)
      kpr_pkg::OP_TICK: begin
        if (p_mode == kpr_pkg::MODE_REC) begin
          p_countdown -= longint'(r.dt);
          if (p_countdown < 0) o.st = store_pose(r);
        end else if (p_mode == kpr_pkg::MODE_FOLLOW) begin
          n = slot_keys[p_slot];
          if (p_seg + 1 < n) begin
            a = p_slot * kpr_pkg::MAX_KEYS + p_seg;
            f = p_frac;
            o.pv = 1'b1;
            o.x = 32'(lerp_q16(sx(kx[a]), sx(kx[a+1]), f));
            o.y = 32'(lerp_q16(sx(ky[a]), sx(ky[a+1]), f));
            o.z = 32'(lerp_q16(sx(kz[a]), sx(kz[a+1]), f));
            cy = sx(kyaw[a]); ny = sx(kyaw[a+1]);
            if (ny - cy > 205887) cy += 411775;
            else if (cy - ny > 205887) ny += 411775;
            yv = lerp_q16(cy, ny, f);
            if (yv > 64'sd2147483647) yv = 64'sd2147483647;
            o.yaw = 32'(yv);
            o.pitch = 32'(lerp_q16(sx(kpitch[a]), sx(kpitch[a+1]), f));
            inc = (longint'(r.dt) * p_recip) >> 16;
            if (inc >= 64'(65536 - f)) f = 65536;
            else f += 32'(inc);
            if (f > 64880) begin
              p_seg++;
              f = 0;
              if (p_seg + 1 >= n) p_mode = kpr_pkg::MODE_IDLE;
            end
            p_frac = f;
          end else begin
            p_mode = kpr_pkg::MODE_IDLE;
          end
        end
      end
      kpr_pkg::OP_START: begin
        if (p_mode != kpr_pkg::MODE_IDLE) o.st = kpr_pkg::ST_IGNORED;
        else begin
          p_slot = 32'(r.slot);
          slot_keys[p_slot] = 0;
          p_mode = kpr_pkg::MODE_REC;
          o.st = store_pose(r);
        end
      end
      kpr_pkg::OP_FINISH: begin
        if (p_mode != kpr_pkg::MODE_REC) o.st = kpr_pkg::ST_IGNORED;
        else begin
          o.st = store_pose(r);
          p_mode = kpr_pkg::MODE_IDLE;
        end
      end
      kpr_pkg::OP_CANCEL: begin
        if (p_mode != kpr_pkg::MODE_REC) o.st = kpr_pkg::ST_IGNORED;
        else begin
          slot_keys[p_slot] = 0;
          p_mode = kpr_pkg::MODE_IDLE;
        end
      end
      kpr_pkg::OP_FOLLOW: begin
        if (p_mode == kpr_pkg::MODE_REC || slot_keys[r.slot] < 2) o.st = kpr_pkg::ST_IGNORED;
        else begin
          p_mode = kpr_pkg::MODE_FOLLOW;
          p_slot = 32'(r.slot);
          p_seg = 0;
          p_frac = 0;
        end
      end
      kpr_pkg::OP_STOP: begin
        if (p_mode != kpr_pkg::MODE_FOLLOW) o.st = kpr_pkg::ST_IGNORED;
        else p_mode = kpr_pkg::MODE_IDLE;
      end
      default: o.st = kpr_pkg::ST_IGNORED;
    endcase
    o.mode = p_mode;
    o.cnt = 7'(slot_keys[p_slot]);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver: each side pauses for a randomly drawn gap between transactions
  int send_gap = 0;
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 7);
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_reqs.size() > 0) begin
          req_item_t r;
          r = pending_reqs.pop_front();
          req_type <= r.req; path_slot <= r.slot; dt <= r.dt;
          cam_x <= r.x; cam_y <= r.y; cam_z <= r.z; cam_yaw <= r.yaw; cam_pitch <= r.pitch;
          in_valid <= 1'b1;
        end
      end
      if (out_taken) recv_gap = $urandom_range(0, 7);
      else if (recv_gap > 0) recv_gap--;
      out_stall <= (recv_gap > 0);
    end
  end

  // accept-side prediction and monitor
  always @(posedge clk) begin
    cycles++;
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (in_taken) begin
      req_item_t r;
      r = {req_type, path_slot, dt, cam_x, cam_y, cam_z, cam_yaw, cam_pitch};
      expected_poses.insert(expected_poses.size(), predict_pose(r));
    end
    if (out_taken) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected result transaction", 32'd0, 32'd0);
      end else begin
        pose_result_t e;
        e = expected_poses.pop_front();
        if (pose_valid !== e.pv) report_mismatch("pose_valid", 32'(pose_valid), 32'(e.pv));
        if (pose_x !== e.x) report_mismatch("pose_x", pose_x, e.x);
        if (pose_y !== e.y) report_mismatch("pose_y", pose_y, e.y);
        if (pose_z !== e.z) report_mismatch("pose_z", pose_z, e.z);
        if (pose_yaw !== e.yaw) report_mismatch("pose_yaw", pose_yaw, e.yaw);
        if (pose_pitch !== e.pitch) report_mismatch("pose_pitch", pose_pitch, e.pitch);
        if (mode_now !== e.mode) report_mismatch("mode_now", 32'(mode_now), 32'(e.mode));
        if (key_count !== e.cnt) report_mismatch("key_count", 32'(key_count), 32'(e.cnt));
        if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
      end
    end
    if (cycles > 1500000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_req(int op, int s, int d);
    req_item_t r;
    r.req = 3'(op); r.slot = 2'(s); r.dt = 31'(d);
    r.x = $urandom; r.y = $urandom; r.z = $urandom; r.yaw = $urandom; r.pitch = $urandom;
    if ($urandom_range(0, 3) == 0) r.yaw = $urandom_range(0, 800000) - 400000;
    pending_reqs.insert(pending_reqs.size(), r);
    items_added++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_poses.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_KEY_INTERVAL) p_interval = 64'(data[30:0]);
    else p_recip = 64'(data);
  endtask

  // mostly short dt values, with zero, the maximum and full-range random ones mixed in
  function automatic int rand_dt();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'h7fffffff;
      2: return int'($urandom & 32'h7fffffff);
      default: return int'($urandom_range(0, 40000));
    endcase
  endfunction

  // a recording session then a following run over the same slot
  task automatic add_session(int keys_hint);
    int s;
    s = $urandom_range(0, 3);
    add_req(kpr_pkg::OP_START, s, 0);
    repeat (keys_hint) add_req(kpr_pkg::OP_TICK, 0,
                               $urandom_range(0, 1) ? 32'h7fffffff : rand_dt());
    if ($urandom_range(0, 9) == 0) add_req(kpr_pkg::OP_CANCEL, 0, 0);
    else add_req(kpr_pkg::OP_FINISH, 0, 0);
    add_req(kpr_pkg::OP_FOLLOW, s, 0);
    repeat ($urandom_range(2, 30)) add_req(kpr_pkg::OP_TICK, 0, rand_dt());
    if ($urandom_range(0, 3) == 0) add_req(kpr_pkg::OP_STOP, 0, 0);
  endtask

  initial begin
    for (int i = 0; i < kpr_pkg::NUM_SLOTS; i++) slot_keys[i] = 0;
    p_mode = kpr_pkg::MODE_IDLE; p_slot = 0; p_seg = 0; p_frac = 0; p_countdown = 0;
    p_interval = 65536; p_recip = 65536;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: ignored requests, full slot, extremes, yaw wrap
    add_req(kpr_pkg::OP_TICK, 0, 32'h7fffffff);
    add_req(kpr_pkg::OP_FINISH, 0, 0);
    add_req(kpr_pkg::OP_CANCEL, 0, 0);
    add_req(kpr_pkg::OP_STOP, 0, 0);
    add_req(kpr_pkg::OP_FOLLOW, 1, 0);
    add_req(kpr_pkg::OP_BAD, 0, 0);
    add_req(REQ_RSVD, 3, 0);
    add_req(kpr_pkg::OP_START, 3, 0);
    add_req(kpr_pkg::OP_START, 2, 0);
    add_req(kpr_pkg::OP_FOLLOW, 3, 0);
    add_req(kpr_pkg::OP_TICK, 0, 32'h7fffffff);
    add_req(kpr_pkg::OP_FINISH, 0, 0);
    add_req(kpr_pkg::OP_FOLLOW, 3, 0);
    add_req(kpr_pkg::OP_START, 1, 0);
    add_req(kpr_pkg::OP_TICK, 0, 32'h10000);
    add_req(kpr_pkg::OP_TICK, 0, 0);
    add_req(kpr_pkg::OP_STOP, 0, 0);
    add_req(kpr_pkg::OP_STOP, 0, 0);
    add_req(kpr_pkg::OP_START, 0, 0);
    repeat (66) add_req(kpr_pkg::OP_TICK, 0, 32'h7fffffff);
    add_req(kpr_pkg::OP_FINISH, 0, 0);
    add_req(kpr_pkg::OP_FOLLOW, 0, 0);
    repeat (20) add_req(kpr_pkg::OP_TICK, 0, 32'h7fffffff);
    pending_reqs[7].yaw = 32'h7fff0000;
    pending_reqs[10].yaw = 32'h80010000;
    pending_reqs[11].x = 32'h80000000;
    pending_reqs[11].yaw = 32'h7fffffff;
    wait_drained();

    // random sessions across register settings, draining before each register change
    apb_write(ADDR_KEY_INTERVAL, 32'h7fffffff);
    apb_write(ADDR_RECIP, 32'hffffffff);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin apb_write(ADDR_KEY_INTERVAL, 1); apb_write(ADDR_RECIP, 0); end
        2: begin apb_write(ADDR_KEY_INTERVAL, 20000); apb_write(ADDR_RECIP, 200000); end
        3: begin
          apb_write(ADDR_KEY_INTERVAL, $urandom_range(1, 100000));
          apb_write(ADDR_RECIP, $urandom);
        end
        4: begin apb_write(ADDR_KEY_INTERVAL, 65536); apb_write(ADDR_RECIP, 65536); end
        5: begin apb_write(ADDR_KEY_INTERVAL, 30000); apb_write(ADDR_RECIP, 3000); end
        default: ;
      endcase
      while (items_added < 325 * (phase + 1)) begin
        if ($urandom_range(0, 7) == 0) begin
          add_req($urandom_range(0, 7), $urandom_range(0, 3), rand_dt());
        end else begin
          add_session($urandom_range(0, 12));
        end
      end
      wait_drained();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/kpr_pkg.sv
rtl/core/kpr_ram.sv
rtl/core/kpr_front.sv
rtl/core/kpr_back.sv
rtl/core/keyframe_path_record_playback.sv
sim/keyframe_path_record_playback_test.sv
